@@ hw/rtl/fdem_pkg.sv @@
// Shared types, constants and helper functions of the directory entry matcher.
`timescale 1ns / 1ps

package fdem_pkg;

  // Default size of the name store
  localparam int unsigned MAX_NAME_DEF = 255;

  // Long-name entry layout
  localparam int unsigned LFN_CHARS   = 13;
  localparam int unsigned ENTRY_BYTES = 32;
  localparam int unsigned SHORT_CHARS = 8;
  localparam int unsigned CSUM_BYTES  = 11;
  localparam int unsigned CSUM_SPLIT  = 6;

  localparam logic [4:0] LFN_POS [LFN_CHARS] =
    '{5'd1, 5'd3, 5'd5, 5'd7, 5'd9, 5'd14, 5'd16, 5'd18, 5'd20, 5'd22, 5'd24, 5'd28, 5'd30};

  // Marker bytes
  localparam logic [7:0] MARK_END     = 8'h00;
  localparam logic [7:0] MARK_DEL     = 8'hE5;
  localparam logic [7:0] MARK_DEL_ALT = 8'h05;
  localparam logic [7:0] CHAR_PAD     = 8'hFF;
  localparam logic [3:0] ATTR_LONG    = 4'hF;
  localparam logic [7:0] CHAR_LOW_A   = 8'h61;
  localparam logic [7:0] CHAR_LOW_Z   = 8'h7A;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  // Byte offsets inside an entry
  localparam int unsigned OFS_ATTR = 11;
  localparam int unsigned OFS_CSUM = 13;

  typedef enum logic [1:0] {
    CMD_RESTART = 2'd0,
    CMD_LOAD    = 2'd1,
    CMD_ENTRY   = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_NONE  = 2'd0,
    ST_MATCH = 2'd1,
    ST_END   = 2'd2
  } status_t;

  // One rotate-add step of the short-name checksum
  function automatic logic [7:0] csum_step(input logic [7:0] sum, input logic [7:0] b);
    csum_step = {sum[0], sum[7:1]} + b;
  endfunction

  // Quotient by the long-name slice length: reciprocal estimate, then one correction
  function automatic logic [7:0] div13(input logic [7:0] x);
    logic [14:0] prod;
    logic [7:0]  q;
    logic [11:0] back;
    logic [7:0]  rem;
    prod = {7'd0, x} * 15'd79;
    q    = prod[14:10] == 5'd0 ? 8'd0 : {3'd0, prod[14:10]};
    back = {4'd0, q} * 12'd13;
    rem  = x - back[7:0];
    if (rem >= 8'd13) begin
      q = q + 8'd1;
    end
    div13 = q;
  endfunction

endpackage

@@ hw/rtl/fdem_if.sv @@
// Channel interfaces of the directory entry matcher: entry/name input and match result.
`timescale 1ns / 1ps

interface fdem_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [7:0]  target_len;
  logic [7:0]  name_index;
  logic [7:0]  name_byte;
  logic [63:0] entry_word0;
  logic [63:0] entry_word1;
  logic [63:0] entry_word2;
  logic [63:0] entry_word3;

  modport source (
    output valid, cmd, target_len, name_index, name_byte,
           entry_word0, entry_word1, entry_word2, entry_word3,
    input  ready
  );
  modport sink (
    input  valid, cmd, target_len, name_index, name_byte,
           entry_word0, entry_word1, entry_word2, entry_word3,
    output ready
  );
endinterface

interface fdem_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] start_cluster;
  logic [31:0] file_size;

  modport source (output valid, status, start_cluster, file_size, input ready);
  modport sink (input valid, status, start_cluster, file_size, output ready);
endinterface

@@ hw/rtl/fat_directory_entry_matcher_top.sv @@
// Top level of the directory entry matcher: name store, match stage and result register.
//
// The block takes one item per clock cycle with no gaps while the result side does not stall,
// and answers each with exactly one result transfer, via the match stage and result register.
// The searched name lives in thirteen column RAMs of ceil(MAX_NAME/13) rows each, so that one
// row read returns the whole thirteen-character slice a long-name entry is compared with;
// that single read port, issued while the item is taken in, is what sets the one-item-per-cycle
// figure. Name loads write the same RAMs at transfer time, so a load is seen by every entry
// taken after it with no forwarding. The first eight name characters are also held in
// registers for the short-name compare. The name store needs no clearing pass after reset:
// positions at or past the search length read as zero, and nothing else is defined before
// it is written. Long-name checksum and compare state lives in flip-flops and updates as the
// match stage hands its result on; the result register lets the next item in while a result
// still waits for its transfer.
`timescale 1ns / 1ps

module fat_directory_entry_matcher_top
  import fdem_pkg::*;
#(
  parameter int unsigned MAX_NAME = MAX_NAME_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  fdem_in_if.sink    in_chan,
  fdem_out_if.source out_chan
);

  localparam int unsigned ROWS  = (MAX_NAME + LFN_CHARS - 1) / LFN_CHARS;
  localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  // ---------------------------------------------------------------------------
  // Handshake and pipeline control
  // ---------------------------------------------------------------------------
  logic s1_v_r, s1_v_nxt;
  logic out_v_r;
  logic s1_go;
  logic in_take;

  // The match stage may hand on whenever the result register is free or being drained
  assign s1_go         = !out_v_r || out_chan.ready;
  assign in_chan.ready = !s1_v_r || s1_go;
  assign in_take       = in_chan.valid && in_chan.ready;

  // ---------------------------------------------------------------------------
  // Name store writes (at transfer time)
  // ---------------------------------------------------------------------------
  logic [7:0]       wr_q;
  logic [11:0]      wr_back;
  logic [7:0]       wr_col;
  logic             wr_en;
  logic [ROW_W-1:0] wr_row;

  assign wr_q    = div13(in_chan.name_index);
  assign wr_back = {4'd0, wr_q} * 12'd13;
  assign wr_col  = in_chan.name_index - wr_back[7:0];
  assign wr_row  = wr_q[ROW_W-1:0];
  // Drop loads beyond the store
  assign wr_en   = in_take && (in_chan.cmd == CMD_LOAD) &&
                   (32'(in_chan.name_index) < MAX_NAME);

  // Read the slice row of a long-name entry; out-of-range rows are masked later
  logic [4:0]       rd_seq;
  logic [4:0]       rd_row5;
  logic [ROW_W-1:0] rd_addr;
  logic             rd_en;

  assign rd_seq  = in_chan.entry_word0[4:0];
  assign rd_row5 = rd_seq - 5'd1;
  assign rd_addr = (rd_seq != 5'd0 && 32'(rd_row5) < ROWS) ? rd_row5[ROW_W-1:0] : '0;
  assign rd_en   = in_take && (in_chan.cmd == CMD_ENTRY);

  logic [7:0] col_rdata [LFN_CHARS];

  for (genvar c = 0; c < LFN_CHARS; c++) begin : g_col
    fdem_ram #(
      .WIDTH (8),
      .DEPTH (ROWS)
    ) u_col_ram (
      .clk   (clk),
      .we    (wr_en && (wr_col == 8'(c))),
      .waddr (wr_row),
      .wdata (in_chan.name_byte),
      .re    (rd_en),
      .raddr (rd_addr),
      .rdata (col_rdata[c])
    );
  end

  // Copy of the first name characters for the short-name compare
  logic [7:0] sname_r [SHORT_CHARS];

  always_ff @(posedge clk) begin
    if (in_take && in_chan.cmd == CMD_LOAD && in_chan.name_index < 8'(SHORT_CHARS)) begin
      sname_r[in_chan.name_index[2:0]] <= in_chan.name_byte;
    end
  end

  // ---------------------------------------------------------------------------
  // Match stage payload; the first six checksum bytes are folded in on the way
  // ---------------------------------------------------------------------------
  logic [1:0]   s1_cmd_r;
  logic [7:0]   s1_len_r;
  logic [255:0] s1_entry_r;
  logic [7:0]   s1_csum_r;
  logic [7:0]   in_csum;
  logic [255:0] in_entry;

  assign in_entry = {in_chan.entry_word3, in_chan.entry_word2,
                     in_chan.entry_word1, in_chan.entry_word0};

  always_comb begin
    in_csum = 8'd0;
    for (int k = 0; k < CSUM_SPLIT; k++) begin
      in_csum = csum_step(in_csum, in_entry[8*k +: 8]);
    end
  end

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_take) begin
      s1_v_nxt = 1'b1;
    end else if (s1_go) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cmd_r   <= in_chan.cmd;
      s1_len_r   <= in_chan.target_len;
      s1_entry_r <= in_entry;
      s1_csum_r  <= in_csum;
    end
  end

  // ---------------------------------------------------------------------------
  // Match stage
  // ---------------------------------------------------------------------------
  logic [7:0] len_r, len_nxt;
  logic [7:0] pend_r, pend_nxt;
  logic       lfn_ok_r, lfn_ok_nxt;

  logic [7:0]  eb [ENTRY_BYTES];
  logic [4:0]  seq;
  logic [8:0]  base;
  logic [8:0]  pos;
  logic [7:0]  nm [LFN_CHARS];
  logic        lfn_stop;
  logic        long_hit;
  logic [7:0]  lc;
  logic [7:0]  csum;
  logic        short_match;
  logic [7:0]  sc;
  logic        hit;
  logic [1:0]  res_status;
  logic [31:0] res_cluster;
  logic [31:0] res_size;

  always_comb begin
    for (int k = 0; k < ENTRY_BYTES; k++) begin
      eb[k] = s1_entry_r[8*k +: 8];
    end
  end

  assign seq  = eb[0][4:0];
  assign base = 9'(LFN_CHARS) * ({4'd0, seq} - 9'd1);

  // Slice of the name for this sequence number; zero past the length or the store
  always_comb begin
    for (int i = 0; i < LFN_CHARS; i++) begin
      pos   = base + 9'(i);
      nm[i] = (seq != 5'd0 && pos < {1'b0, len_r} && pos < 9'(MAX_NAME)) ?
              col_rdata[i] : 8'd0;
    end
  end

  // Compare up to the first terminator or pad character
  always_comb begin
    lfn_stop = 1'b0;
    long_hit = 1'b1;
    for (int i = 0; i < LFN_CHARS; i++) begin
      lc = eb[LFN_POS[i]];
      if (!lfn_stop) begin
        if (lc == MARK_END || lc == CHAR_PAD) begin
          lfn_stop = 1'b1;
        end else if (lc != nm[i]) begin
          long_hit = 1'b0;
        end
      end
    end
  end

  always_comb begin
    csum = s1_csum_r;
    for (int k = CSUM_SPLIT; k < CSUM_BYTES; k++) begin
      csum = csum_step(csum, eb[k]);
    end
  end

  // Case-folded compare of the first characters
  always_comb begin
    short_match = 1'b1;
    for (int i = 0; i < SHORT_CHARS; i++) begin
      sc = sname_r[i];
      if (sc >= CHAR_LOW_A && sc <= CHAR_LOW_Z) begin
        sc = sc - CASE_OFFSET;
      end
      if (8'(i) < len_r && sc != eb[i]) begin
        short_match = 1'b0;
      end
    end
  end

  always_comb begin
    len_nxt     = len_r;
    pend_nxt    = pend_r;
    lfn_ok_nxt  = lfn_ok_r;
    res_status  = ST_NONE;
    res_cluster = 32'd0;
    res_size    = 32'd0;
    hit         = 1'b0;
    unique case (s1_cmd_r)
      CMD_RESTART: begin
        len_nxt    = s1_len_r;
        pend_nxt   = 8'd0;
        lfn_ok_nxt = 1'b1;
      end
      CMD_LOAD: begin
        // store already written at transfer time
      end
      CMD_ENTRY: begin
        if (eb[0] == MARK_END) begin
          res_status = ST_END;
          pend_nxt   = 8'd0;
          lfn_ok_nxt = 1'b1;
        end else if (eb[0] == MARK_DEL || eb[0] == MARK_DEL_ALT) begin
          // skip deleted entry, keep state
        end else if (eb[OFS_ATTR][3:0] == ATTR_LONG) begin
          if (!long_hit) begin
            lfn_ok_nxt = 1'b0;
          end
          pend_nxt = eb[OFS_CSUM];
        end else begin
          if (len_r == 8'd0) begin
            hit = 1'b0;
          end else if (pend_r != 8'd0 && lfn_ok_r) begin
            hit = (csum == pend_r);
          end else begin
            hit = short_match;
          end
          if (hit) begin
            res_status  = ST_MATCH;
            res_cluster = {eb[21], eb[20], eb[27], eb[26]};
            res_size    = {eb[31], eb[30], eb[29], eb[28]};
          end
          pend_nxt   = 8'd0;
          lfn_ok_nxt = 1'b1;
        end
      end
      default: begin
        // unused command: no effect
      end
    endcase
  end

  // Advance search state only as the match stage hands its result on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r    <= 8'd0;
      pend_r   <= 8'd0;
      lfn_ok_r <= 1'b1;
    end else if (s1_v_r && s1_go) begin
      len_r    <= len_nxt;
      pend_r   <= pend_nxt;
      lfn_ok_r <= lfn_ok_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic [1:0]  out_status_r;
  logic [31:0] out_cluster_r;
  logic [31:0] out_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_go) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_v_r) begin
      out_status_r  <= res_status;
      out_cluster_r <= res_cluster;
      out_size_r    <= res_size;
    end
  end

  assign out_chan.valid         = out_v_r;
  assign out_chan.status        = out_status_r;
  assign out_chan.start_cluster = out_cluster_r;
  assign out_chan.file_size     = out_size_r;

endmodule

@@ hw/rtl/fdem_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module fdem_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 20,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sim/tb_top.sv @@
// Self-checking bench for the directory entry matcher: preloaded name, searches and noise.
`timescale 1ns / 1ps

module tb_top;
  import fdem_pkg::*;

  // Name store depth seen by the block at its default size
  localparam int unsigned NAME_CAP = MAX_NAME_DEF;
  // The one command code the package leaves unnamed: the block must ignore it
  localparam logic [1:0] CMD_SPARE = 2'd3;
  // Flag in byte 0 of the first long-name entry of a run
  localparam logic [7:0] LAST_LONG = 8'h40;

  // Shapes of a generated search
  localparam int RUN_CHECKSUM = 0; // long-name run, short entry matched by checksum
  localparam int NAME_ONLY    = 1; // bare short entry, case-folded name compare
  localparam int RUN_SPOILT   = 2; // long-name run with one bad character
  localparam int CHECKSUM_OFF = 3; // long-name run carrying the wrong checksum

  localparam int RANDOM_ITEMS  = 1500;
  localparam int CALM_TAIL     = 200;  // last items: no idling on either side
  localparam int DRAIN_EVERY   = 500;  // sender waits for every result this often
  localparam int IDLE_LIMIT    = 1000; // cycles with no transfer before giving up
  localparam int SETTLE_CYCLES = 16;
  localparam int PRINT_CAP     = 40;

  typedef struct packed {
    logic [1:0]   cmd;
    logic [7:0]   target_len;
    logic [7:0]   name_index;
    logic [7:0]   name_byte;
    logic [255:0] entry;          // byte k sits at [8k +: 8]
    logic         hold_for_drain; // present only once every result is in
    logic         calm;           // part of the idle-free tail
  } dir_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] cluster;
    logic [31:0] size;
  } lookup_result_t;

  logic clk = 1'b0;
  logic rst_n;

  fdem_in_if  in_bus ();
  fdem_out_if out_bus ();

  fat_directory_entry_matcher_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of the name store and long-name tracking
  // ---------------------------------------------------------------------------
  logic [7:0] name_mem [0:NAME_CAP-1];
  logic [7:0] want_len  = 8'd0;
  logic [7:0] lfn_csum  = 8'd0;
  bit         lfn_ok    = 1'b1;

  // What the generator believes the store holds, used to build matching entries
  logic [7:0] plan_name [0:NAME_CAP-1];

  dir_item_t      item_q [$];
  lookup_result_t predicted_matches [$];
  int             n_sent = 0;  // transfers taken in, updated at the edge
  int             n_seen = 0;  // results checked, updated at the edge
  int             mismatch_count = 0;
  int             dead_cycles = 0;
  bit             calm_run = 1'b0;
  bit             drain_next = 1'b0;
  int             calm_from = 32'h7fff_ffff;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Positions at or past the searched length read as zero
  function automatic logic [7:0] name_char(int unsigned pos);
    if (pos >= want_len || pos >= NAME_CAP) return 8'd0;
    return name_mem[pos];
  endfunction

  function automatic logic [7:0] sfn_checksum(logic [255:0] e);
    logic [7:0] sum;
    int k;
    sum = 8'd0;
    for (k = 0; k < CSUM_BYTES; k++) begin
      sum = ((sum & 8'h01) << 7) + (sum >> 1) + e[8*k +: 8];
    end
    return sum;
  endfunction

  // Compare the thirteen characters up to the first terminator or pad; sequence zero reads zeros
  function automatic bit lfn_agrees(logic [255:0] e);
    int unsigned seq;
    int unsigned i;
    logic [7:0] c;
    logic [7:0] n;
    seq = e[4:0];
    for (i = 0; i < LFN_CHARS; i++) begin
      c = e[8*LFN_POS[i] +: 8];
      if (c == MARK_END || c == CHAR_PAD) break;
      n = (seq == 0) ? 8'd0 : name_char(LFN_CHARS * (seq - 1) + i);
      if (c != n) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Upper-case the name and compare up to eight characters
  function automatic bit short_agrees(logic [255:0] e);
    int unsigned n;
    int unsigned i;
    logic [7:0] c;
    n = (want_len > SHORT_CHARS) ? SHORT_CHARS : want_len;
    for (i = 0; i < n; i++) begin
      c = name_char(i);
      if (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) c = c - CASE_OFFSET;
      if (c != e[8*i +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Advance the predictor by one accepted item and return the result it owes
  function automatic lookup_result_t predict_lookup(dir_item_t it);
    lookup_result_t r;
    logic [7:0] b0;
    bit hit;
    r = '0;
    case (it.cmd)
      CMD_RESTART: begin
        want_len = it.target_len;
        lfn_csum = 8'd0;
        lfn_ok   = 1'b1;
      end
      CMD_LOAD: begin
        if (it.name_index < NAME_CAP) name_mem[it.name_index] = it.name_byte;
      end
      CMD_ENTRY: begin
        b0 = it.entry[7:0];
        if (b0 == MARK_END) begin
          r.status = ST_END;
          lfn_csum = 8'd0;
          lfn_ok   = 1'b1;
        end else if (b0 == MARK_DEL || b0 == MARK_DEL_ALT) begin
          // deleted entry: state stays as it is
        end else if (it.entry[8*OFS_ATTR +: 4] == ATTR_LONG) begin
          if (!lfn_agrees(it.entry)) lfn_ok = 1'b0;
          lfn_csum = it.entry[8*OFS_CSUM +: 8];
        end else begin
          if (want_len == 8'd0) begin
            hit = 1'b0;
          end else if (lfn_csum != 8'd0 && lfn_ok) begin
            hit = (sfn_checksum(it.entry) == lfn_csum);
          end else begin
            hit = short_agrees(it.entry);
          end
          if (hit) begin
            r.status  = ST_MATCH;
            // high half from bytes 20..21, low half from bytes 26..27
            r.cluster = {it.entry[175:160], it.entry[223:208]};
            r.size    = it.entry[255:224];
          end
          lfn_csum = 8'd0;
          lfn_ok   = 1'b1;
        end
      end
      default: begin
        // spare command: nothing changes
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------------------

  function automatic logic [255:0] rand_entry();
    logic [255:0] v;
    int w;
    for (w = 0; w < 8; w++) v[32*w +: 32] = $urandom;
    return v;
  endfunction

  // Half lower-case letters, a fifth upper-case, the rest random bytes, so that the case fold gets exercised
  function automatic logic [7:0] name_letter();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return CHAR_LOW_A + 8'($urandom_range(0, 25));
    if (r < 70) return CHAR_LOW_A - CASE_OFFSET + 8'($urandom_range(0, 25));
    return 8'($urandom);
  endfunction

  // Every payload field random, so unused fields toggle too
  function automatic dir_item_t fresh_item(logic [1:0] cmd);
    dir_item_t it;
    it.cmd            = cmd;
    it.target_len     = 8'($urandom);
    it.name_index     = 8'($urandom);
    it.name_byte      = 8'($urandom);
    it.entry          = rand_entry();
    it.hold_for_drain = 1'b0;
    it.calm           = 1'b0;
    return it;
  endfunction

  task automatic add_item(dir_item_t it);
    it.calm           = (item_q.size() >= calm_from);
    it.hold_for_drain = drain_next;
    drain_next        = 1'b0;
    if (it.cmd == CMD_LOAD && it.name_index < NAME_CAP) plan_name[it.name_index] = it.name_byte;
    item_q.push_back(it);
  endtask

  task automatic add_restart(int len);
    dir_item_t it;
    it = fresh_item(CMD_RESTART);
    it.target_len = 8'(len);
    add_item(it);
  endtask

  task automatic add_load(int idx, logic [7:0] b);
    dir_item_t it;
    it = fresh_item(CMD_LOAD);
    it.name_index = 8'(idx);
    it.name_byte  = b;
    add_item(it);
  endtask

  task automatic add_entry(logic [255:0] e);
    dir_item_t it;
    it = fresh_item(CMD_ENTRY);
    it.entry = e;
    add_item(it);
  endtask

  // Short entry: either the folded name in bytes 0..7 or random content
  function automatic logic [255:0] build_short(int len, bit use_name);
    logic [255:0] e;
    logic [7:0] c;
    int i;
    e = rand_entry();
    if (use_name) begin
      for (i = 0; i < len && i < SHORT_CHARS; i++) begin
        c = plan_name[i];
        if (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) c = c - CASE_OFFSET;
        e[8*i +: 8] = c;
      end
    end else if (e[7:0] == MARK_END || e[7:0] == MARK_DEL || e[7:0] == MARK_DEL_ALT) begin
      e[7:0] = CHAR_LOW_A - CASE_OFFSET;
    end
    if (e[8*OFS_ATTR +: 4] == ATTR_LONG) e[8*OFS_ATTR +: 4] = 4'd0;
    return e;
  endfunction

  // Long-name entry holding slice seq of the planned name, terminated and padded
  function automatic logic [255:0] build_long(int seq, bit last, int len, logic [7:0] csum);
    logic [255:0] e;
    int i;
    int pos;
    e = rand_entry();
    e[4:0] = 5'(seq);
    e[6]   = last;
    e[8*OFS_ATTR +: 4] = ATTR_LONG;
    e[8*OFS_CSUM +: 8] = csum;
    for (i = 0; i < LFN_CHARS; i++) begin
      pos = LFN_CHARS * (seq - 1) + i;
      if (pos < len)       e[8*LFN_POS[i] +: 8] = plan_name[pos];
      else if (pos == len) e[8*LFN_POS[i] +: 8] = MARK_END;
      else                 e[8*LFN_POS[i] +: 8] = CHAR_PAD;
    end
    return e;
  endfunction

  // Restart, zero to three name edits, a long-name run unless name-only, the short entry, sometimes an end marker
  task automatic add_search(int len, int shape);
    logic [255:0] sfn;
    logic [255:0] e;
    logic [7:0] csum;
    int slices;
    int seq;
    int spoil;
    add_restart(len);
    if (len > 0) begin
      repeat ($urandom_range(0, 3)) add_load($urandom_range(0, len - 1), name_letter());
    end
    sfn = build_short(len, shape == NAME_ONLY || shape == RUN_SPOILT || $urandom_range(0, 1));
    if (shape != NAME_ONLY) begin
      csum = sfn_checksum(sfn);
      if (shape == CHECKSUM_OFF) csum = csum ^ 8'($urandom_range(1, 255));
      slices = (len == 0) ? 1 : (len + LFN_CHARS - 1) / LFN_CHARS;
      spoil  = $urandom_range(1, slices);
      for (seq = slices; seq >= 1; seq--) begin
        e = build_long(seq, seq == slices, len, csum);
        if (shape == RUN_SPOILT && seq == spoil) begin
          e[8*LFN_POS[$urandom_range(0, LFN_CHARS - 1)] +: 8] ^= 8'h01 << $urandom_range(0, 7);
        end
        add_entry(e);
        // drop a deleted entry into the run now and then
        if ($urandom_range(0, 9) == 0) begin
          e = rand_entry();
          e[7:0] = $urandom_range(0, 1) ? MARK_DEL : MARK_DEL_ALT;
          add_entry(e);
        end
      end
    end
    add_entry(sfn);
    if ($urandom_range(0, 4) == 0) begin
      e = rand_entry();
      e[7:0] = MARK_END;
      add_entry(e);
    end
  endtask

  // Mostly short names, a few up to the full store
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3)  return 0;
    if (r < 80) return $urandom_range(1, 20);
    if (r < 95) return $urandom_range(21, 60);
    return $urandom_range(61, NAME_CAP);
  endfunction

  // Garbage of every kind: all commands, markers, forced long-name attributes
  function automatic dir_item_t noise_item();
    dir_item_t it;
    it = fresh_item(2'($urandom_range(0, 3)));
    case ($urandom_range(0, 5))
      0: it.entry[7:0] = MARK_END;
      1: it.entry[7:0] = MARK_DEL;
      2: it.entry[7:0] = MARK_DEL_ALT;
      3: it.entry[8*OFS_ATTR +: 4] = ATTR_LONG;
      default: begin
      end
    endcase
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Reporting
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(string msg);
    if (mismatch_count < PRINT_CAP) $display("%0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: present queued items, idle in bursts, hold for drains
  // ---------------------------------------------------------------------------
  dir_item_t on_bus;
  int gap_left = 0;
  int gap_pct  = 0;
  int taken    = 0;

  always @(posedge clk) begin : drive_items
    bit took;
    bit go;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      gap_left = 0;
    end else begin
      took = in_bus.valid && in_bus.ready;
      if (took) begin
        predicted_matches.push_back(predict_lookup(on_bus));
        n_sent <= n_sent + 1;
        taken++;
        // re-pick the gap rate now and then so that stretches without idling occur
        if (taken % 100 == 0) begin
          case ($urandom_range(0, 2))
            0: gap_pct = 0;
            1: gap_pct = 8;
            default: gap_pct = 30;
          endcase
        end
        if (!on_bus.calm && $urandom_range(0, 99) < gap_pct) gap_left = $urandom_range(1, 18);
      end
      // Hold the payload while a transfer is still pending
      if (!in_bus.valid || took) begin
        go = (item_q.size() > 0) && (gap_left == 0);
        // a drain item waits until every transfer so far has its result back
        if (go && item_q[0].hold_for_drain && (took || n_seen != n_sent)) go = 1'b0;
        if (gap_left > 0) gap_left--;
        if (go) begin
          on_bus = item_q.pop_front();
          in_bus.cmd         <= on_bus.cmd;
          in_bus.target_len  <= on_bus.target_len;
          in_bus.name_index  <= on_bus.name_index;
          in_bus.name_byte   <= on_bus.name_byte;
          in_bus.entry_word0 <= on_bus.entry[63:0];
          in_bus.entry_word1 <= on_bus.entry[127:64];
          in_bus.entry_word2 <= on_bus.entry[191:128];
          in_bus.entry_word3 <= on_bus.entry[255:192];
          calm_run           <= on_bus.calm;
        end
        in_bus.valid <= go;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver back-pressure: bursts of stall, rate changing over the run
  // ---------------------------------------------------------------------------
  int stall_left = 0;
  int stall_pct  = 0;
  int rx_cycles  = 0;

  always @(posedge clk) begin : pace_results
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      stall_left = 0;
    end else begin
      rx_cycles++;
      if (rx_cycles % 97 == 0) begin
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 5;
          default: stall_pct = 25;
        endcase
      end
      if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else if (!calm_run && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(1, 18) - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each result transfer with the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    lookup_result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (n_seen < n_sent) begin
        want = predicted_matches[n_seen];
        if (out_bus.status !== want.status)
          flag_mismatch($sformatf("result %0d: status %0d, predicted %0d",
                                  n_seen, out_bus.status, want.status));
        if (out_bus.start_cluster !== want.cluster)
          flag_mismatch($sformatf("result %0d: start_cluster %h, predicted %h",
                                  n_seen, out_bus.start_cluster, want.cluster));
        if (out_bus.file_size !== want.size)
          flag_mismatch($sformatf("result %0d: file_size %h, predicted %h",
                                  n_seen, out_bus.file_size, want.size));
        n_seen <= n_seen + 1;
      end else begin
        flag_mismatch("result transfer with no prediction outstanding");
      end
    end
  end

  // Count cycles in which neither side moves a transfer
  always @(posedge clk) begin
    if (!rst_n)
      dead_cycles <= 0;
    else if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
      dead_cycles <= 0;
    else
      dead_cycles <= dead_cycles + 1;
  end

  initial begin : watchdog
    @(posedge rst_n);
    while (dead_cycles < IDLE_LIMIT) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : run
    dir_item_t it;
    logic [255:0] e;
    int idx;
    int rand_start;
    int next_drain;

    rst_n               = 1'b0;
    in_bus.valid        = 1'b0;
    in_bus.cmd          = CMD_RESTART;
    in_bus.target_len   = 8'd0;
    in_bus.name_index   = 8'd0;
    in_bus.name_byte    = 8'd0;
    in_bus.entry_word0  = 64'd0;
    in_bus.entry_word1  = 64'd0;
    in_bus.entry_word2  = 64'd0;
    in_bus.entry_word3  = 64'd0;
    out_bus.ready       = 1'b0;

    // Fill the whole name store first, so no later read can land on an unwritten position
    for (idx = 0; idx < NAME_CAP; idx++) add_load(idx, name_letter());

    // Directed part: spare command, load past the store, store ends
    add_item(fresh_item(CMD_SPARE));
    add_load(NAME_CAP, name_letter());
    add_load(NAME_CAP - 1, CHAR_PAD);
    add_load(0, CHAR_LOW_A);

    // Empty name: a valid-looking run still must not match
    add_search(0, RUN_CHECKSUM);

    // Longest length; sequence zero and a sequence past the end of the store
    add_restart(NAME_CAP);
    e = rand_entry();
    e[7:0] = LAST_LONG;
    e[8*OFS_ATTR +: 4] = ATTR_LONG;
    add_entry(e);
    e = rand_entry();
    e[7:0] = LAST_LONG | 8'h1F;
    e[8*OFS_ATTR +: 4] = ATTR_LONG;
    add_entry(e);
    add_entry(build_short(NAME_CAP, 1'b1));

    // End marker with every other bit set; both deletion marks on long-name attributes
    e = '1;
    e[7:0] = MARK_END;
    add_entry(e);
    e = rand_entry();
    e[7:0] = MARK_DEL;
    e[8*OFS_ATTR +: 4] = ATTR_LONG;
    add_entry(e);
    e[7:0] = MARK_DEL_ALT;
    add_entry(e);

    // One search of each shape
    add_search(5, RUN_CHECKSUM);
    add_search(3, NAME_ONLY);
    add_search(13, RUN_SPOILT);
    add_search(14, CHECKSUM_OFF);

    // Random part: mostly well-formed searches, the rest noise
    rand_start = item_q.size();
    calm_from  = rand_start + RANDOM_ITEMS - CALM_TAIL;
    next_drain = rand_start;
    while (item_q.size() < rand_start + RANDOM_ITEMS) begin
      if (item_q.size() >= next_drain) begin
        drain_next = 1'b1;
        next_drain += DRAIN_EVERY;
      end
      if ($urandom_range(0, 99) < 75) begin
        add_search(pick_len(), $urandom_range(RUN_CHECKSUM, CHECKSUM_OFF));
      end else begin
        it = noise_item();
        add_item(it);
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Wait until every item is in and every prediction has been met
    while (item_q.size() != 0 || in_bus.valid || n_seen != n_sent) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
